FILE: rtl/keymx_pkg.sv
package keymx_pkg;

    // Default matrix size
    localparam int ROWS_DEF    = 8;
    localparam int COLUMNS_DEF = 8;

    // Field widths fixed by the interface
    localparam int THRESH_W = 4;
    localparam int BYTE_W   = 8;
    localparam int ROW_OUT_W = 3;

    localparam logic [THRESH_W-1:0] THRESH_RESET  = 4'd5;
    localparam logic [BYTE_W-1:0]   PAST_END_BYTE = 8'hFF;

    // Item operation codes
    typedef enum logic [1:0] {
        MODE_SCAN       = 2'd0,
        MODE_READ_START = 2'd1,
        MODE_READ_NEXT  = 2'd2,
        MODE_IGNORED    = 2'd3
    } mode_t;

    // Control shared by all column lanes
    typedef struct packed {
        logic                scan;
        logic [THRESH_W-1:0] threshold;
    } lane_ctrl_t;

endpackage

FILE: rtl/keymx_lane.sv
module keymx_lane
    import keymx_pkg::*;
#(
    parameter int ROWS = ROWS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lane_ctrl_t              ctrl,
    input  logic [$clog2(ROWS)-1:0] row_sel,
    input  logic                    level,
    output logic                    pressed
);

    logic [THRESH_W-1:0] cnt_reg [ROWS];
    logic [THRESH_W-1:0] cnt_cur;
    logic [THRESH_W-1:0] cnt_next;

    // Look up the counter of the key in the selected row
    assign cnt_cur = cnt_reg[row_sel];

    // Key is down and its counter has reached the threshold
    assign pressed = !level && (cnt_cur >= ctrl.threshold);

    // Clear on release, count up while below the threshold, else hold
    always_comb begin
        if (level) begin
            cnt_next = '0;
        end else if (cnt_cur < ctrl.threshold) begin
            cnt_next = cnt_cur + THRESH_W'(1);
        end else begin
            cnt_next = cnt_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++) begin
                cnt_reg[r] <= '0;
            end
        end else if (ctrl.scan) begin
            cnt_reg[row_sel] <= cnt_next;
        end
    end

endmodule

FILE: rtl/keymx_merge.sv
module keymx_merge
    import keymx_pkg::*;
#(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLUMNS = COLUMNS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_fire,
    input  logic [1:0]              mode,
    input  logic [$clog2(ROWS)-1:0] row_sel,
    input  logic [COLUMNS-1:0]      lane_pressed,
    output logic                    in_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ROW_OUT_W-1:0]    m_scanned_row,
    output logic [BYTE_W-1:0]       m_row_keys,
    output logic [BYTE_W-1:0]       m_read_byte
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int PTR_W = $clog2(ROWS + 1);

    logic [COLUMNS-1:0]     rows_reg [ROWS];
    logic [PTR_W-1:0]       ptr_reg;
    logic [PTR_W-1:0]       ptr_next;
    logic                   m_valid_reg;
    logic [ROW_OUT_W-1:0]   scanned_row_reg;
    logic [BYTE_W-1:0]      row_keys_reg;
    logic [BYTE_W-1:0]      read_byte_reg;
    logic [ROW_OUT_W-1:0]   scanned_row_next;
    logic [BYTE_W-1:0]      row_keys_next;
    logic [BYTE_W-1:0]      read_byte_next;
    logic [ROW_W+ROW_OUT_W-1:0] row_wide;
    logic [COLUMNS+BYTE_W-1:0]  keys_wide;
    logic [COLUMNS+BYTE_W-1:0]  first_wide;
    logic [COLUMNS+BYTE_W-1:0]  ptr_wide;
    logic                   is_scan;

    // Take a new item whenever the output register is empty or draining
    assign in_ready = !m_valid_reg || m_ready;
    assign is_scan  = in_fire && (mode_t'(mode) == MODE_SCAN);

    // Fit row index and row bytes to the fixed result widths
    assign row_wide   = {{ROW_OUT_W{1'b0}}, row_sel};
    assign keys_wide  = {{BYTE_W{1'b0}}, lane_pressed};
    assign first_wide = {{BYTE_W{1'b0}}, rows_reg[0]};
    assign ptr_wide   = {{BYTE_W{1'b0}}, rows_reg[ptr_reg[ROW_W-1:0]]};

    // Build the result and the next read pointer
    always_comb begin
        scanned_row_next = '0;
        row_keys_next    = '0;
        read_byte_next   = '0;
        ptr_next         = ptr_reg;
        unique case (mode_t'(mode))
            MODE_SCAN: begin
                scanned_row_next = row_wide[ROW_OUT_W-1:0];
                row_keys_next    = keys_wide[BYTE_W-1:0];
            end
            MODE_READ_START: begin
                read_byte_next = first_wide[BYTE_W-1:0];
                ptr_next       = PTR_W'(1);
            end
            MODE_READ_NEXT: begin
                if (ptr_reg >= PTR_W'(ROWS)) begin
                    read_byte_next = PAST_END_BYTE;
                    ptr_next       = PTR_W'(ROWS);
                end else begin
                    read_byte_next = ptr_wide[BYTE_W-1:0];
                    ptr_next       = ptr_reg + PTR_W'(1);
                end
            end
            default: begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    // Hold control state and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            ptr_reg     <= '0;
            for (int r = 0; r < ROWS; r++) begin
                rows_reg[r] <= '0;
            end
        end else begin
            if (in_fire) begin
                m_valid_reg <= 1'b1;
                ptr_reg     <= ptr_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (is_scan) begin
                rows_reg[row_sel] <= lane_pressed;
            end
        end
    end

    // Load result payload on each accepted item
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            scanned_row_reg <= scanned_row_next;
            row_keys_reg    <= row_keys_next;
            read_byte_reg   <= read_byte_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_scanned_row = scanned_row_reg;
    assign m_row_keys    = row_keys_reg;
    assign m_read_byte   = read_byte_reg;

endmodule

FILE: rtl/keypad_matrix_debounce_scanner.sv
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_mode[1:0], s_column_levels[7:0]
// m_        out        m_valid / m_ready      m_scanned_row[2:0], m_row_keys[7:0],
//                                             m_read_byte[7:0]
// cfg_      in         cfg_valid / cfg_ready  cfg_data[3:0] (debounce threshold)
//
// One item per cycle unless m_ready stalls; each result appears in the cycle after
// its item is accepted, from the single output register behind the column lanes.
// Synchronous active-low reset clears all key counters, stored rows and pointers
// at once, and sets the threshold to 5; no clearing pass is needed.
// A stalled m_ready holds the result; the next item is still taken in the cycle
// the held result drains.
module keypad_matrix_debounce_scanner
    import keymx_pkg::*;
#(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLUMNS = COLUMNS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_mode,
    input  logic [BYTE_W-1:0]    s_column_levels,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ROW_OUT_W-1:0] m_scanned_row,
    output logic [BYTE_W-1:0]    m_row_keys,
    output logic [BYTE_W-1:0]    m_read_byte,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [THRESH_W-1:0]  cfg_data
);

    localparam int ROW_W = $clog2(ROWS);

    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [THRESH_W-1:0] threshold_reg;
    logic                s_fire;
    lane_ctrl_t          lane_ctrl;
    logic [COLUMNS-1:0]  lane_pressed;

    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Advance the row index cyclically
    always_comb begin
        if (row_reg == ROW_W'(ROWS - 1)) begin
            row_next = '0;
        end else begin
            row_next = row_reg + ROW_W'(1);
        end
    end

    assign lane_ctrl.scan      = s_fire && (mode_t'(s_mode) == MODE_SCAN);
    assign lane_ctrl.threshold = threshold_reg;

    // Hold row index and threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= '0;
            threshold_reg <= THRESH_RESET;
        end else begin
            if (lane_ctrl.scan) begin
                row_reg <= row_next;
            end
            if (cfg_valid) begin
                threshold_reg <= cfg_data;
            end
        end
    end

    // One debounce lane per column
    for (genvar c = 0; c < COLUMNS; c++) begin : g_lane
        keymx_lane #(
            .ROWS (ROWS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .row_sel (row_next),
            .level   (s_column_levels[c]),
            .pressed (lane_pressed[c])
        );
    end

    // Combine lane bits, store rows and serve reads
    keymx_merge #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (s_fire),
        .mode          (s_mode),
        .row_sel       (row_next),
        .lane_pressed  (lane_pressed),
        .in_ready      (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_scanned_row (m_scanned_row),
        .m_row_keys    (m_row_keys),
        .m_read_byte   (m_read_byte)
    );

endmodule

FILE: tb/sv/keypad_scan_checker.sv
`timescale 1ns / 1ps

module keypad_scan_checker
    import keymx_pkg::*;
#(
    parameter int ROWS    = ROWS_DEF,
    parameter int COLUMNS = COLUMNS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [1:0]           s_mode,
    input  logic [BYTE_W-1:0]    s_column_levels,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [ROW_OUT_W-1:0] m_scanned_row,
    input  logic [BYTE_W-1:0]    m_row_keys,
    input  logic [BYTE_W-1:0]    m_read_byte,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [THRESH_W-1:0]  cfg_data,
    output int                   fail_count,
    output int                   due_count
);

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [BYTE_W-1:0]    keys;
        logic [BYTE_W-1:0]    rbyte;
    } key_result_t;

    // Shadow copy of the scanner state
    logic [THRESH_W-1:0] thresh_q;
    int                  scan_row;
    logic [3:0]          key_count [ROWS*COLUMNS];
    logic [BYTE_W-1:0]   pressed_rows [ROWS];
    int                  read_ptr;

    key_result_t due_outputs [$];
    key_result_t oldest;

    initial begin
        fail_count = 0;
        due_count  = 0;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t ns: mismatch on %s, expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        fail_count++;
    endtask

    // Apply one item to the shadow state and return the output it produces
    function automatic key_result_t keypad_step(input mode_t md, input logic [BYTE_W-1:0] levels);
        key_result_t       r;
        logic [BYTE_W-1:0] keys;
        int                idx;
        r    = '0;
        keys = '0;
        case (md)
            MODE_SCAN: begin
                scan_row = (scan_row >= ROWS - 1) ? 0 : scan_row + 1;
                for (int c = 0; c < COLUMNS; c++) begin
                    idx = scan_row * COLUMNS + c;
                    if (levels[c]) begin
                        key_count[idx] = '0;
                    end else if (key_count[idx] < thresh_q) begin
                        key_count[idx] = key_count[idx] + 4'd1;
                    end else begin
                        keys[c] = 1'b1;
                    end
                end
                pressed_rows[scan_row] = keys;
                r.row  = scan_row[ROW_OUT_W-1:0];
                r.keys = keys;
            end
            MODE_READ_START: begin
                read_ptr = 1;
                r.rbyte  = pressed_rows[0];
            end
            MODE_READ_NEXT: begin
                // Hold the pointer at the end once every row has gone out
                if (read_ptr >= ROWS) begin
                    read_ptr = ROWS;
                    r.rbyte  = PAST_END_BYTE;
                end else begin
                    r.rbyte  = pressed_rows[read_ptr];
                    read_ptr = read_ptr + 1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Track config writes, predict accepted items, compare drained results
    always @(posedge aclk) begin
        if (!aresetn) begin
            thresh_q = THRESH_RESET;
            scan_row = 0;
            read_ptr = 0;
            foreach (key_count[i]) key_count[i] = '0;
            foreach (pressed_rows[i]) pressed_rows[i] = '0;
            due_outputs.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                thresh_q = cfg_data;
            end
            if (s_valid && s_ready) begin
                due_outputs.push_back(keypad_step(mode_t'(s_mode), s_column_levels));
            end
            if (m_valid && m_ready) begin
                if (due_outputs.size() == 0) begin
                    report_mismatch("result with no item pending", 0, m_read_byte);
                end else begin
                    oldest = due_outputs.pop_front();
                    if (m_scanned_row !== oldest.row)
                        report_mismatch("scanned_row", oldest.row, m_scanned_row);
                    if (m_row_keys !== oldest.keys)
                        report_mismatch("row_keys", oldest.keys, m_row_keys);
                    if (m_read_byte !== oldest.rbyte)
                        report_mismatch("read_byte", oldest.rbyte, m_read_byte);
                end
            end
        end
        due_count = due_outputs.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import keymx_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 6;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic [1:0]           s_mode          = MODE_SCAN;
    logic [BYTE_W-1:0]    s_column_levels = '1;
    logic                 m_ready         = 1'b0;
    logic                 cfg_valid       = 1'b0;
    logic [THRESH_W-1:0]  cfg_data        = '0;
    logic                 s_ready;
    logic                 m_valid;
    logic [ROW_OUT_W-1:0] m_scanned_row;
    logic [BYTE_W-1:0]    m_row_keys;
    logic [BYTE_W-1:0]    m_read_byte;
    logic                 cfg_ready;
    int                   fail_count;
    int                   due_count;

    bit                   idle_on       = 1'b1;
    bit                   long_hold_req = 1'b0;
    int                   stall_cycles  = 0;
    int                   scans_sent    = 0;
    logic [BYTE_W-1:0]    row_pattern [ROWS_DEF];

    keypad_matrix_debounce_scanner u_dut (.*);

    keypad_scan_checker u_checker (.*);

    always #2 aclk = ~aclk;

    // End the run when no channel has moved for too long
    always @(posedge aclk) begin
        if (aresetn && !(s_valid && s_ready) && !(m_valid && m_ready) && !(cfg_valid && cfg_ready))
            stall_cycles++;
        else
            stall_cycles = 0;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random backpressure bursts, one long hold on request
    initial begin
        int burst;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                long_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 13);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one item, maybe after an idle burst, and hold it until taken
    task automatic send_item(input mode_t md, input logic [BYTE_W-1:0] lv);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= md;
        s_column_levels <= lv;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly steady key patterns with some bounce, plus read sweeps and noise
    task automatic run_phase(input int n_items);
        int                done;
        int                pick;
        int                sweep_len;
        logic [BYTE_W-1:0] lv;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if ($urandom_range(0, 63) == 0)
                    row_pattern[scans_sent % ROWS_DEF] = BYTE_W'($urandom_range(0, 255));
                lv = row_pattern[scans_sent % ROWS_DEF];
                if ($urandom_range(0, 15) == 0) lv[3'($urandom_range(0, 7))] ^= 1'b1;
                send_item(MODE_SCAN, lv);
                scans_sent++;
                done++;
            end else if (pick < 80) begin
                sweep_len = $urandom_range(7, 10);
                send_item(MODE_READ_START, BYTE_W'($urandom_range(0, 255)));
                repeat (sweep_len) send_item(MODE_READ_NEXT, BYTE_W'($urandom_range(0, 255)));
                done += sweep_len + 1;
            end else if (pick < 90) begin
                send_item(MODE_READ_NEXT, BYTE_W'($urandom_range(0, 255)));
                done++;
            end else if (pick < 95) begin
                send_item(MODE_READ_START, BYTE_W'($urandom_range(0, 255)));
                done++;
            end else begin
                send_item(MODE_IGNORED, BYTE_W'($urandom_range(0, 255)));
                done++;
            end
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] early_levels [4] = '{8'h00, 8'hFF, 8'hAA, 8'h55};
        logic [BYTE_W-1:0] fast_levels [8] = '{8'h00, 8'hA5, 8'h5A, 8'hFF,
                                               8'h0F, 8'hF0, 8'h7E, 8'h81};
        int                thr_plan [6]    = '{0, 15, -1, 1, 9, -1};
        int                len_plan [6]    = '{120, 260, 140, 120, 140, 150};

        foreach (row_pattern[i]) row_pattern[i] = BYTE_W'($urandom_range(0, 255));
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset threshold: read before any start, ignored mode, first counts
        send_item(MODE_READ_NEXT, 8'h00);
        send_item(MODE_IGNORED, 8'hFF);
        send_item(MODE_IGNORED, 8'h00);
        foreach (early_levels[i]) send_item(MODE_SCAN, early_levels[i]);
        send_item(MODE_READ_START, 8'hFF);

        // Zero threshold: keys press on the first low sample, then read all rows
        write_threshold(4'd0);
        foreach (fast_levels[i]) send_item(MODE_SCAN, fast_levels[i]);
        send_item(MODE_READ_START, 8'h00);
        repeat (9) send_item(MODE_READ_NEXT, 8'hFF);

        // Random phases across threshold settings, idle-free at the end
        for (int p = 0; p < 6; p++) begin
            write_threshold(THRESH_W'((thr_plan[p] < 0) ? $urandom_range(2, 14) : thr_plan[p]));
            idle_on = (p != 5);
            if (p == 1) long_hold_req = 1'b1;
            run_phase(len_plan[p]);
        end

        drain();
        if (fail_count == 0 && due_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
